@@ hdl/tpcd_pkg.sv @@
// Shared types and constants for the tracker pattern cell decoder.
// Holds the per-channel entry layout, volume/pan kinds and the volume/pan sort.
// No dependencies.
package tpcd_pkg;

  typedef enum logic [3:0] {
    VP_NONE      = 4'd0,
    VP_VOL       = 4'd1,
    VP_PAN       = 4'd2,
    VP_FINEVOLUP = 4'd3,
    VP_FINEVOLDN = 4'd4,
    VP_SLIDEUP   = 4'd5,
    VP_SLIDEDN   = 4'd6,
    VP_PITCHDN   = 4'd7,
    VP_PITCHUP   = 4'd8,
    VP_PORTA     = 4'd9,
    VP_VIBDEPTH  = 4'd10
  } volpan_kind_t;

  // 47-bit channel entry
  typedef struct packed {
    logic         has_note;
    logic [7:0]   note;
    logic         has_instrument;
    logic [7:0]   instrument;
    logic         has_volpan;
    volpan_kind_t volpan_kind;
    logic [6:0]   volpan_amount;
    logic         has_command;
    logic [7:0]   command;
    logic [7:0]   command_value;
  } chan_entry_t;

  localparam int unsigned ENTRY_W = $bits(chan_entry_t);

  localparam logic [7:0] DELAY_CODE_RESET = 8'd19;
  localparam logic [3:0] DELAY_PARAM_HI   = 4'hD;
  localparam logic       REG_DELAY_CODE   = 1'b0;

  function automatic void sort_volpan(input logic [7:0] v, output volpan_kind_t kind,
                                      output logic [6:0] amount);
    logic [7:0] diff;
    diff = 8'd0;
    kind = VP_NONE;
    if (v <= 8'd64) begin
      kind = VP_VOL;       diff = v;
    end else if (v >= 8'd128 && v <= 8'd192) begin
      kind = VP_PAN;       diff = v - 8'd128;
    end else if (v >= 8'd65 && v <= 8'd74) begin
      kind = VP_FINEVOLUP; diff = v - 8'd65;
    end else if (v >= 8'd75 && v <= 8'd84) begin
      kind = VP_FINEVOLDN; diff = v - 8'd75;
    end else if (v >= 8'd85 && v <= 8'd94) begin
      kind = VP_SLIDEUP;   diff = v - 8'd85;
    end else if (v >= 8'd95 && v <= 8'd104) begin
      kind = VP_SLIDEDN;   diff = v - 8'd95;
    end else if (v >= 8'd105 && v <= 8'd114) begin
      kind = VP_PITCHDN;   diff = v - 8'd105;
    end else if (v >= 8'd115 && v <= 8'd124) begin
      kind = VP_PITCHUP;   diff = v - 8'd115;
    end else if (v >= 8'd193 && v <= 8'd202) begin
      kind = VP_PORTA;     diff = v - 8'd193;
    end else if (v >= 8'd203 && v <= 8'd212) begin
      kind = VP_VIBDEPTH;  diff = v - 8'd203;
    end
    amount = diff[6:0];
  endfunction

endpackage

@@ hdl/tracker_pattern_cell_decoder.sv @@
// Top level of the tracker pattern cell decoder: channel memory, merge stage, APB register.
// Depends on tpcd_pkg and tpcd_ram.
//
// Decodes one packed pattern cell per transaction and sustains one transaction per clock
// while the output is not stalled. The channel entry is read from the synchronous channel
// RAM at the edge that accepts the transaction; when the merge stage fires, it combines new
// and remembered fields, writes the entry back and loads the output register. Back-to-back
// cells on the same channel are served by forwarding the last written entry. Reset clears
// the per-channel valid flags at once, so no clearing pass is needed. Register 0 at byte
// address 0 holds the note delay command code (reset 19); write it only while the decoder
// is idle.
module tracker_pattern_cell_decoder #(
  parameter int NUM_CHANNELS = 64
) (
  input  logic        clk,
  input  logic        rst,
  // APB
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [5:0]  channel,
  input  logic [7:0]  mask,
  input  logic [7:0]  note_in,
  input  logic [7:0]  instrument_in,
  input  logic [7:0]  volpan_in,
  input  logic [7:0]  command_in,
  input  logic [7:0]  command_value_in,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        has_note,
  output logic [7:0]  note_out,
  output logic        has_instrument,
  output logic [7:0]  instrument_out,
  output logic        has_volpan,
  output logic [3:0]  volpan_kind,
  output logic [6:0]  volpan_amount,
  output logic        has_command,
  output logic [7:0]  command_out,
  output logic [7:0]  command_value_out,
  output logic        is_empty,
  output logic [3:0]  trigger_tick
);
  import tpcd_pkg::*;

  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // configuration
  logic [7:0] delay_code;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_DELAY_CODE);
  assign prdata    = (paddr[2] == REG_DELAY_CODE) ? {24'd0, delay_code} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_code <= DELAY_CODE_RESET;
    end else if (cfg_write) begin
      delay_code <= pwdata[7:0];
    end
  end

  // channel index wraps modulo NUM_CHANNELS
  logic [14:0]   rem;
  logic [AW-1:0] rd_addr;

  always_comb begin
    rem = {9'd0, channel};
    for (int k = 5; k >= 0; k--) begin
      if (rem >= 15'(NUM_CHANNELS << k)) begin
        rem = rem - 15'(NUM_CHANNELS << k);
      end
    end
    rd_addr = rem[AW-1:0];
  end

  // handshake
  logic accept;
  logic s1_valid;
  logic s1_fire;

  assign s1_fire  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_fire;
  assign accept   = in_valid && !in_stall;

  // stage 1 registers
  logic [AW-1:0] s1_addr;
  logic [7:0]    s1_mask;
  logic [7:0]    s1_note;
  logic [7:0]    s1_instrument;
  logic [7:0]    s1_volpan;
  logic [7:0]    s1_command;
  logic [7:0]    s1_command_value;
  logic          s1_old_valid;

  logic [NUM_CHANNELS-1:0] entry_valid;

  logic        fwd_valid;
  logic [AW-1:0] fwd_addr;
  chan_entry_t fwd_data;

  logic [ENTRY_W-1:0] ram_rdata;
  chan_entry_t        old_entry;
  chan_entry_t        new_entry;
  chan_entry_t        merged;
  volpan_kind_t       vp_kind;
  logic [6:0]         vp_amount;
  logic [3:0]         tick;
  logic               empty;

  tpcd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_CHANNELS)
  ) u_chan_ram (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_addr),
    .wdata (new_entry),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    sort_volpan(s1_volpan, vp_kind, vp_amount);

    if (fwd_valid && fwd_addr == s1_addr) begin
      old_entry = fwd_data;
    end else if (s1_old_valid) begin
      old_entry = chan_entry_t'(ram_rdata);
    end else begin
      old_entry = '0;
    end

    new_entry = old_entry;
    merged    = '0;

    if (s1_mask[4]) begin
      merged.has_note = old_entry.has_note;
      merged.note     = old_entry.note;
    end
    if (s1_mask[5]) begin
      merged.has_instrument = old_entry.has_instrument;
      merged.instrument     = old_entry.instrument;
    end
    if (s1_mask[6]) begin
      merged.has_volpan    = old_entry.has_volpan;
      merged.volpan_kind   = old_entry.volpan_kind;
      merged.volpan_amount = old_entry.volpan_amount;
    end
    if (s1_mask[7]) begin
      merged.has_command   = old_entry.has_command;
      merged.command       = old_entry.command;
      merged.command_value = old_entry.command_value;
    end

    if (s1_mask[0]) begin
      merged.has_note    = 1'b1;
      merged.note        = s1_note;
      new_entry.has_note = 1'b1;
      new_entry.note     = s1_note;
    end
    if (s1_mask[1]) begin
      merged.has_instrument    = 1'b1;
      merged.instrument        = s1_instrument;
      new_entry.has_instrument = 1'b1;
      new_entry.instrument     = s1_instrument;
    end
    if (s1_mask[2]) begin
      merged.has_volpan       = 1'b1;
      merged.volpan_kind      = vp_kind;
      merged.volpan_amount    = vp_amount;
      new_entry.has_volpan    = 1'b1;
      new_entry.volpan_kind   = vp_kind;
      new_entry.volpan_amount = vp_amount;
    end
    if (s1_mask[3]) begin
      merged.has_command      = 1'b1;
      merged.command          = s1_command;
      merged.command_value    = s1_command_value;
      new_entry.has_command   = 1'b1;
      new_entry.command       = s1_command;
      new_entry.command_value = s1_command_value;
    end

    empty = !(merged.has_note || merged.has_instrument || merged.has_volpan
              || merged.has_command);

    if (merged.has_command && merged.command == delay_code
        && merged.command_value[7:4] == DELAY_PARAM_HI) begin
      tick = merged.command_value[3:0];
    end else begin
      tick = 4'd0;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      fwd_valid   <= 1'b0;
      entry_valid <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        out_valid             <= 1'b1;
        fwd_valid             <= 1'b1;
        entry_valid[s1_addr]  <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  chan_entry_t out_cell;
  logic        out_empty;
  logic [3:0]  out_tick;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr          <= rd_addr;
      s1_mask          <= mask;
      s1_note          <= note_in;
      s1_instrument    <= instrument_in;
      s1_volpan        <= volpan_in;
      s1_command       <= command_in;
      s1_command_value <= command_value_in;
      s1_old_valid     <= entry_valid[rd_addr];
    end
    if (s1_fire) begin
      fwd_addr  <= s1_addr;
      fwd_data  <= new_entry;
      out_cell  <= merged;
      out_empty <= empty;
      out_tick  <= tick;
    end
  end

  assign has_note          = out_cell.has_note;
  assign note_out          = out_cell.note;
  assign has_instrument    = out_cell.has_instrument;
  assign instrument_out    = out_cell.instrument;
  assign has_volpan        = out_cell.has_volpan;
  assign volpan_kind       = out_cell.volpan_kind;
  assign volpan_amount     = out_cell.volpan_amount;
  assign has_command       = out_cell.has_command;
  assign command_out       = out_cell.command;
  assign command_value_out = out_cell.command_value;
  assign is_empty          = out_empty;
  assign trigger_tick      = out_tick;

  // checks
  a_accept_to_s1: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted transaction did not reach merge stage");

  a_fwd_tracks_write: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> fwd_valid && fwd_addr == $past(s1_addr))
    else $error("forward register missed a write-back");

  a_tick_needs_delay: assert property (@(posedge clk) disable iff (rst)
    out_valid && trigger_tick != 4'd0 |->
      has_command && command_value_out[7:4] == DELAY_PARAM_HI)
    else $error("trigger tick without note delay command");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> is_empty == !(has_note || has_instrument || has_volpan || has_command))
    else $error("empty flag disagrees with presence flags");

  a_none_zero_amount: assert property (@(posedge clk) disable iff (rst)
    out_valid && volpan_kind == VP_NONE |-> volpan_amount == 7'd0)
    else $error("volume/pan amount set for unlisted code");

endmodule

@@ hdl/tpcd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tpcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output logic [WIDTH-1:0]     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ tb/tracker_pattern_cell_decoder_tb.sv @@
// Self-checking testbench for tracker_pattern_cell_decoder: directed cell table, then random cells.
// Predicts untyped cells with its own per-channel memory model; checks over the APB port too.
// Depends on tpcd_pkg and the decoder RTL.
module tracker_pattern_cell_decoder_tb;
  import tpcd_pkg::*;

  typedef struct packed {
    logic [5:0] channel;
    logic [7:0] mask;
    logic [7:0] note;
    logic [7:0] instrument;
    logic [7:0] volpan;
    logic [7:0] command;
    logic [7:0] command_value;
  } cell_txn_t;

  typedef struct packed {
    chan_entry_t f;
    logic        is_empty;
    logic [3:0]  tick;
  } cell_result_t;

  typedef struct {
    cell_txn_t    txn;
    bit           typed;
    cell_result_t r;
  } dir_row_t;

  localparam logic [2:0] DELAY_CODE_ADDR = {REG_DELAY_CODE, 2'b00};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [5:0]  channel = '0;
  logic [7:0]  mask = '0;
  logic [7:0]  note_in = '0;
  logic [7:0]  instrument_in = '0;
  logic [7:0]  volpan_in = '0;
  logic [7:0]  command_in = '0;
  logic [7:0]  command_value_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        has_note;
  logic [7:0]  note_out;
  logic        has_instrument;
  logic [7:0]  instrument_out;
  logic        has_volpan;
  logic [3:0]  volpan_kind;
  logic [6:0]  volpan_amount;
  logic        has_command;
  logic [7:0]  command_out;
  logic [7:0]  command_value_out;
  logic        is_empty;
  logic [3:0]  trigger_tick;

  tracker_pattern_cell_decoder dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  chan_entry_t  chan_mem [64];
  logic [7:0]   cur_delay_code = DELAY_CODE_RESET;
  cell_result_t pending_cells[$];
  int           mismatches = 0;
  int           cells_checked = 0;
  int           delay_triggers = 0;
  int           config_writes = 0;
  bit           tx_idle_on = 1'b1;
  logic         rx_idle_on = 1'b1;
  int           hold_req = 0;
  int           hold_seen = 0;
  int           hold_left = 0;
  int           stall_left = 0;

  initial begin
    foreach (chan_mem[i]) chan_mem[i] = '0;
  end

  function automatic void classify_volpan(input logic [7:0] v, output volpan_kind_t k,
                                          output logic [6:0] a);
    int unsigned off;
    k = VP_NONE;
    a = '0;
    if (v <= 8'd64) begin
      k = VP_VOL;
      a = v[6:0];
    end else if (v >= 8'd128 && v <= 8'd192) begin
      k = VP_PAN;
      a = 7'(v - 8'd128);
    end else if (v >= 8'd65 && v <= 8'd124) begin
      // six ten-wide bands starting at fine volume up
      off = v - 8'd65;
      k = volpan_kind_t'(4'(int'(VP_FINEVOLUP) + off / 10));
      a = 7'(off % 10);
    end else if (v >= 8'd193 && v <= 8'd212) begin
      off = v - 8'd193;
      k = volpan_kind_t'(4'(int'(VP_PORTA) + off / 10));
      a = 7'(off % 10);
    end
  endfunction

  function automatic cell_result_t decode_cell(input cell_txn_t t);
    cell_result_t r;
    chan_entry_t  m;
    volpan_kind_t k;
    logic [6:0]   a;
    m = chan_mem[t.channel];
    r = '0;
    if (t.mask[4]) {r.f.has_note, r.f.note} = {m.has_note, m.note};
    if (t.mask[5]) {r.f.has_instrument, r.f.instrument} = {m.has_instrument, m.instrument};
    if (t.mask[6]) begin
      r.f.has_volpan = m.has_volpan;
      r.f.volpan_kind = m.volpan_kind;
      r.f.volpan_amount = m.volpan_amount;
    end
    if (t.mask[7]) begin
      r.f.has_command = m.has_command;
      r.f.command = m.command;
      r.f.command_value = m.command_value;
    end
    if (t.mask[0]) begin
      {r.f.has_note, r.f.note} = {1'b1, t.note};
      {m.has_note, m.note} = {1'b1, t.note};
    end
    if (t.mask[1]) begin
      {r.f.has_instrument, r.f.instrument} = {1'b1, t.instrument};
      {m.has_instrument, m.instrument} = {1'b1, t.instrument};
    end
    if (t.mask[2]) begin
      classify_volpan(t.volpan, k, a);
      r.f.has_volpan = 1'b1;
      r.f.volpan_kind = k;
      r.f.volpan_amount = a;
      m.has_volpan = 1'b1;
      m.volpan_kind = k;
      m.volpan_amount = a;
    end
    if (t.mask[3]) begin
      {r.f.has_command, r.f.command, r.f.command_value} = {1'b1, t.command, t.command_value};
      {m.has_command, m.command, m.command_value} = {1'b1, t.command, t.command_value};
    end
    chan_mem[t.channel] = m;
    r.is_empty = !(r.f.has_note || r.f.has_instrument || r.f.has_volpan || r.f.has_command);
    if (r.f.has_command && r.f.command == cur_delay_code
        && r.f.command_value[7:4] == DELAY_PARAM_HI)
      r.tick = r.f.command_value[3:0];
    return r;
  endfunction

  function automatic cell_txn_t cell_txn(input logic [5:0] ch, input logic [7:0] m, n, i, vp,
                                         c, cv);
    cell_txn_t t;
    t = '{ch, m, n, i, vp, c, cv};
    return t;
  endfunction

  function automatic cell_result_t vp_cell(input volpan_kind_t k, input logic [6:0] a);
    cell_result_t r;
    r = '0;
    r.f.has_volpan = 1'b1;
    r.f.volpan_kind = k;
    r.f.volpan_amount = a;
    return r;
  endfunction

  function automatic cell_txn_t random_cell();
    cell_txn_t t;
    t.channel = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(0, 3));
    case ($urandom_range(0, 3))
      0:       t.mask = {4'($urandom), 4'h0};
      1:       t.mask = {4'h0, 4'($urandom)};
      default: t.mask = 8'($urandom);
    endcase
    t.note = 8'($urandom);
    t.instrument = 8'($urandom);
    t.volpan = 8'($urandom);
    t.command = ($urandom_range(0, 2) == 0) ? cur_delay_code : 8'($urandom);
    t.command_value = ($urandom_range(0, 2) == 0) ? {DELAY_PARAM_HI, 4'($urandom)}
                                                  : 8'($urandom);
    return t;
  endfunction

  task automatic check_field(input string nm, input logic [31:0] exp, input logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, got %0h", nm, exp, act);
      mismatches++;
    end
  endtask

  task automatic compare_cell(input cell_result_t e);
    check_field("has_note", e.f.has_note, has_note);
    check_field("note_out", e.f.note, note_out);
    check_field("has_instrument", e.f.has_instrument, has_instrument);
    check_field("instrument_out", e.f.instrument, instrument_out);
    check_field("has_volpan", e.f.has_volpan, has_volpan);
    check_field("volpan_kind", e.f.volpan_kind, volpan_kind);
    check_field("volpan_amount", e.f.volpan_amount, volpan_amount);
    check_field("has_command", e.f.has_command, has_command);
    check_field("command_out", e.f.command, command_out);
    check_field("command_value_out", e.f.command_value, command_value_out);
    check_field("is_empty", e.is_empty, is_empty);
    check_field("trigger_tick", e.tick, trigger_tick);
  endtask

  // output side: checker plus stall generator
  always @(posedge clk) begin : rx_side
    cell_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_cells.size() == 0) begin
          $error("decoded cell arrived with no pending transaction");
          mismatches++;
        end else begin
          want = pending_cells.pop_front();
          compare_cell(want);
          cells_checked++;
          if (want.tick != 4'd0) delay_triggers++;
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= 300;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 6) == 0) begin
        stall_left <= $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send(input cell_txn_t t, input bit typed, input cell_result_t typed_exp);
    cell_result_t pred;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    {channel, mask, note_in, instrument_in, volpan_in, command_in, command_value_in} <= t;
    do @(posedge clk); while (in_stall);
    pred = decode_cell(t);
    pending_cells.push_back(typed ? typed_exp : pred);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_delay_code(input logic [7:0] code);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= DELAY_CODE_ADDR;
    pwdata <= 32'(code);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cur_delay_code = code;
    config_writes++;
    // read back
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("prdata", 32'(code), prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    #2000000;
    $error("timeout waiting for decoded cells");
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    dir_row_t     dir_rows[$];
    cell_result_t full_max;
    cell_result_t empty_cell;
    logic [7:0]   codes[4];
    int           p;
    int           i;

    empty_cell = '0;
    empty_cell.is_empty = 1'b1;
    full_max = '0;
    full_max.f = '{1'b1, 8'hFF, 1'b1, 8'hFF, 1'b1, VP_NONE, 7'd0, 1'b1, DELAY_CODE_RESET, 8'hDF};
    full_max.tick = 4'hF;

    dir_rows.push_back('{cell_txn(6'd0, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1,
                         empty_cell});
    // reuse of fields never stored
    dir_rows.push_back('{cell_txn(6'd0, 8'hF0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
                         empty_cell});
    dir_rows.push_back('{cell_txn(6'd63, 8'h0F, 8'hFF, 8'hFF, 8'hFF, DELAY_CODE_RESET, 8'hDF),
                         1'b1, full_max});
    dir_rows.push_back('{cell_txn(6'd63, 8'hF0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
                         full_max});
    dir_rows.push_back('{cell_txn(6'd1, 8'h04, 0, 0, 8'd0, 0, 0), 1'b1, vp_cell(VP_VOL, 7'd0)});
    dir_rows.push_back('{cell_txn(6'd1, 8'h04, 0, 0, 8'd64, 0, 0), 1'b1, vp_cell(VP_VOL, 7'd64)});
    dir_rows.push_back('{cell_txn(6'd1, 8'h04, 0, 0, 8'd65, 0, 0), 1'b1,
                         vp_cell(VP_FINEVOLUP, 7'd0)});
    dir_rows.push_back('{cell_txn(6'd1, 8'h04, 0, 0, 8'd84, 0, 0), 1'b1,
                         vp_cell(VP_FINEVOLDN, 7'd9)});
    dir_rows.push_back('{cell_txn(6'd1, 8'h04, 0, 0, 8'd85, 0, 0), 1'b1,
                         vp_cell(VP_SLIDEUP, 7'd0)});
    dir_rows.push_back('{cell_txn(6'd1, 8'h04, 0, 0, 8'd104, 0, 0), 1'b1,
                         vp_cell(VP_SLIDEDN, 7'd9)});
    dir_rows.push_back('{cell_txn(6'd1, 8'h04, 0, 0, 8'd105, 0, 0), 1'b1,
                         vp_cell(VP_PITCHDN, 7'd0)});
    dir_rows.push_back('{cell_txn(6'd1, 8'h04, 0, 0, 8'd124, 0, 0), 1'b1,
                         vp_cell(VP_PITCHUP, 7'd9)});
    dir_rows.push_back('{cell_txn(6'd1, 8'h04, 0, 0, 8'd125, 0, 0), 1'b1, vp_cell(VP_NONE, 7'd0)});
    dir_rows.push_back('{cell_txn(6'd1, 8'h04, 0, 0, 8'd127, 0, 0), 1'b1, vp_cell(VP_NONE, 7'd0)});
    dir_rows.push_back('{cell_txn(6'd1, 8'h04, 0, 0, 8'd128, 0, 0), 1'b1, vp_cell(VP_PAN, 7'd0)});
    dir_rows.push_back('{cell_txn(6'd1, 8'h04, 0, 0, 8'd192, 0, 0), 1'b1, vp_cell(VP_PAN, 7'd64)});
    dir_rows.push_back('{cell_txn(6'd1, 8'h04, 0, 0, 8'd193, 0, 0), 1'b1,
                         vp_cell(VP_PORTA, 7'd0)});
    dir_rows.push_back('{cell_txn(6'd1, 8'h04, 0, 0, 8'd212, 0, 0), 1'b1,
                         vp_cell(VP_VIBDEPTH, 7'd9)});
    dir_rows.push_back('{cell_txn(6'd1, 8'h04, 0, 0, 8'd213, 0, 0), 1'b1, vp_cell(VP_NONE, 7'd0)});
    dir_rows.push_back('{cell_txn(6'd1, 8'h40, 0, 0, 8'd100, 0, 0), 1'b0, '0});
    dir_rows.push_back('{cell_txn(6'd2, 8'h08, 0, 0, 0, DELAY_CODE_RESET, 8'hD0), 1'b0, '0});
    dir_rows.push_back('{cell_txn(6'd2, 8'h08, 0, 0, 0, DELAY_CODE_RESET, 8'hC5), 1'b0, '0});
    dir_rows.push_back('{cell_txn(6'd2, 8'h08, 0, 0, 0, 8'd18, 8'hD7), 1'b0, '0});
    // new fields override reused ones
    dir_rows.push_back('{cell_txn(6'd63, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0, '0});
    dir_rows.push_back('{cell_txn(6'd5, 8'h88, 8'h3C, 8'h01, 8'h20, DELAY_CODE_RESET, 8'hDA),
                         1'b0, '0});

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[k]) send(dir_rows[k].txn, dir_rows[k].typed, dir_rows[k].r);

    codes = '{8'd0, 8'hFF, 8'($urandom_range(1, 254)), DELAY_CODE_RESET};
    for (p = 0; p < 4; p++) begin
      wait_idle();
      write_delay_code(codes[p]);
      if (p == 3) begin
        tx_idle_on = 1'b0;
        rx_idle_on <= 1'b0;
      end
      for (i = 0; i < 300; i++) begin
        // long output hold while the sender keeps pushing
        if (p == 1 && i == 20) begin
          hold_req <= hold_req + 1;
          tx_idle_on = 1'b0;
        end
        if (p == 1 && i == 100) tx_idle_on = 1'b1;
        if (p == 2 && i == 150) wait_idle();
        send(random_cell(), 1'b0, '0);
      end
    end
    wait_idle();

    $display("Checked %0d decoded cells (%0d note delay triggers) over %0d delay code settings.",
             cells_checked, delay_triggers, config_writes + 1);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
